>>> hw/rtl/bhmc_pkg.sv
// Shared types, constants and register map for the button heater mode controller.
package bhmc_pkg;

  // Width of the core's tick counter (15 to 32).
  localparam int unsigned CntW   = 16;
  // Compare width so that 16-bit register values and the counter line up.
  localparam int unsigned CmpW   = (CntW > 16) ? CntW : 16;
  localparam int unsigned PressW = 12;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [PressW-1:0] PressMax = 12'hFFF;
  localparam logic [PressW-1:0] ShortMin = 12'd8;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_LONG_PRESS = 3'd0;
  localparam logic [2:0] REG_STUCK_KEY  = 3'd1;
  localparam logic [2:0] REG_IDLE_SLEEP = 3'd2;
  localparam logic [2:0] REG_DUTY_PER   = 3'd3;
  localparam logic [2:0] REG_PREHEAT    = 3'd4;
  localparam logic [2:0] REG_HIGH_ON    = 3'd5;
  localparam logic [2:0] REG_MID_ON     = 3'd6;
  localparam logic [2:0] REG_LOW_ON     = 3'd7;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_HIGH    = 3'd1,
    MODE_MID     = 3'd2,
    MODE_LOW     = 3'd3,
    MODE_PREHEAT = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2,
    EV_STUCK = 2'd3
  } event_e;

  typedef struct packed {
    logic [11:0] long_press_ticks;
    logic [11:0] stuck_key_ticks;
    logic [15:0] idle_sleep_ticks;
    logic [15:0] duty_period_ticks;
    logic [15:0] preheat_ticks;
    logic [15:0] high_on_ticks;
    logic [15:0] mid_on_ticks;
    logic [15:0] low_on_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] power_mode;
    logic       high_indicator;
    logic       mid_indicator;
    logic       low_indicator;
    logic       heater_drive;
    logic       sleep_request;
  } result_t;

endpackage

>>> hw/rtl/bhmc_cfg.sv
// APB-style configuration register file for the heater controller.
module bhmc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bhmc_pkg::AddrW-1:0]    paddr,
  input  logic [bhmc_pkg::DataW-1:0]    pwdata,
  output logic [bhmc_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output bhmc_pkg::cfg_t                cfg_o
);

  bhmc_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        bhmc_pkg::REG_LONG_PRESS: cfg_d.long_press_ticks  = pwdata[11:0];
        bhmc_pkg::REG_STUCK_KEY:  cfg_d.stuck_key_ticks   = pwdata[11:0];
        bhmc_pkg::REG_IDLE_SLEEP: cfg_d.idle_sleep_ticks  = pwdata[15:0];
        bhmc_pkg::REG_DUTY_PER:   cfg_d.duty_period_ticks = pwdata[15:0];
        bhmc_pkg::REG_PREHEAT:    cfg_d.preheat_ticks     = pwdata[15:0];
        bhmc_pkg::REG_HIGH_ON:    cfg_d.high_on_ticks     = pwdata[15:0];
        bhmc_pkg::REG_MID_ON:     cfg_d.mid_on_ticks      = pwdata[15:0];
        bhmc_pkg::REG_LOW_ON:     cfg_d.low_on_ticks      = pwdata[15:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bhmc_pkg::REG_LONG_PRESS: prdata = {20'd0, cfg_q.long_press_ticks};
      bhmc_pkg::REG_STUCK_KEY:  prdata = {20'd0, cfg_q.stuck_key_ticks};
      bhmc_pkg::REG_IDLE_SLEEP: prdata = {16'd0, cfg_q.idle_sleep_ticks};
      bhmc_pkg::REG_DUTY_PER:   prdata = {16'd0, cfg_q.duty_period_ticks};
      bhmc_pkg::REG_PREHEAT:    prdata = {16'd0, cfg_q.preheat_ticks};
      bhmc_pkg::REG_HIGH_ON:    prdata = {16'd0, cfg_q.high_on_ticks};
      bhmc_pkg::REG_MID_ON:     prdata = {16'd0, cfg_q.mid_on_ticks};
      bhmc_pkg::REG_LOW_ON:     prdata = {16'd0, cfg_q.low_on_ticks};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks  <= 12'd300;
      cfg_q.stuck_key_ticks   <= 12'd3000;
      cfg_q.idle_sleep_ticks  <= 16'd200;
      cfg_q.duty_period_ticks <= 16'd400;
      cfg_q.preheat_ticks     <= 16'd18000;
      cfg_q.high_on_ticks     <= 16'd300;
      cfg_q.mid_on_ticks      <= 16'd200;
      cfg_q.low_on_ticks      <= 16'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hw/rtl/bhmc_core.sv
// Per-tick state update: press classifier, mode sequencer and heater duty timer.
module bhmc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                key_pressed_i,
  input  bhmc_pkg::cfg_t      cfg_i,
  output bhmc_pkg::result_t   res_o
);

  bhmc_pkg::mode_e                   mode_q, mode_d;
  logic [bhmc_pkg::CntW-1:0]         tick_q, tick_d;
  logic [bhmc_pkg::PressW-1:0]       press_q, press_d;
  logic                              seen_q, seen_d;
  logic                              heat_q, heat_d;

  always_comb begin
    bhmc_pkg::event_e          ev;
    logic [15:0]               on_tick;
    logic                      sleep;

    ev      = bhmc_pkg::EV_NONE;
    on_tick = '0;
    sleep   = 1'b0;
    mode_d  = mode_q;
    tick_d  = tick_q;
    press_d = press_q;
    seen_d  = seen_q;
    heat_d  = heat_q;

    // press classifier
    if (key_pressed_i) begin
      if (press_q < bhmc_pkg::PressMax) begin
        press_d = press_q + 12'd1;
      end
      if (press_d >= cfg_i.long_press_ticks) begin
        if (press_d >= cfg_i.stuck_key_ticks) begin
          ev = bhmc_pkg::EV_STUCK;
        end else if (!seen_q) begin
          seen_d = 1'b1;
          ev     = bhmc_pkg::EV_LONG;
        end
      end
    end else begin
      press_d = '0;
      if (press_q >= cfg_i.long_press_ticks) begin
        seen_d = 1'b0;
      end else if (press_q >= bhmc_pkg::ShortMin) begin
        ev = bhmc_pkg::EV_CLICK;
      end
    end

    // preheat countdown, decrement before the zero test
    if (mode_d == bhmc_pkg::MODE_PREHEAT) begin
      tick_d = tick_d - bhmc_pkg::CntW'(1);
      if (tick_d == '0) begin
        mode_d = bhmc_pkg::MODE_MID;
      end
    end

    if (ev == bhmc_pkg::EV_CLICK && mode_d != bhmc_pkg::MODE_OFF) begin
      tick_d = '0;
      if (mode_d >= bhmc_pkg::MODE_LOW) begin
        mode_d = bhmc_pkg::MODE_HIGH;
      end else begin
        mode_d = bhmc_pkg::mode_e'(mode_d + 3'd1);
      end
    end else if (ev == bhmc_pkg::EV_LONG) begin
      if (mode_d != bhmc_pkg::MODE_OFF) begin
        mode_d  = bhmc_pkg::MODE_OFF;
        heat_d  = 1'b0;
        press_d = '0;
        tick_d  = '0;
        sleep   = 1'b1;
      end else begin
        mode_d = bhmc_pkg::MODE_PREHEAT;
        tick_d = bhmc_pkg::CntW'(cfg_i.preheat_ticks);
      end
    end else if (ev == bhmc_pkg::EV_STUCK) begin
      mode_d  = bhmc_pkg::MODE_OFF;
      heat_d  = 1'b0;
      press_d = '0;
      tick_d  = '0;
      sleep   = 1'b1;
    end

    case (mode_d)
      bhmc_pkg::MODE_OFF: begin
        if (press_d == '0) begin
          tick_d = tick_d + bhmc_pkg::CntW'(1);
          if (bhmc_pkg::CmpW'(tick_d) == bhmc_pkg::CmpW'(cfg_i.idle_sleep_ticks)) begin
            heat_d  = 1'b0;
            press_d = '0;
            tick_d  = '0;
            sleep   = 1'b1;
          end
        end
      end
      bhmc_pkg::MODE_HIGH: on_tick = cfg_i.high_on_ticks;
      bhmc_pkg::MODE_MID:  on_tick = cfg_i.mid_on_ticks;
      bhmc_pkg::MODE_LOW:  on_tick = cfg_i.low_on_ticks;
      default:             heat_d  = 1'b1;
    endcase

    // duty timer for the three power levels
    if (mode_d == bhmc_pkg::MODE_HIGH || mode_d == bhmc_pkg::MODE_MID ||
        mode_d == bhmc_pkg::MODE_LOW) begin
      if (bhmc_pkg::CmpW'(tick_d) == bhmc_pkg::CmpW'(on_tick)) begin
        heat_d = 1'b0;
      end
      tick_d = tick_d + bhmc_pkg::CntW'(1);
      if (bhmc_pkg::CmpW'(tick_d) == bhmc_pkg::CmpW'(cfg_i.duty_period_ticks)) begin
        tick_d = '0;
        heat_d = 1'b1;
      end
    end

    res_o.power_mode     = mode_d;
    res_o.high_indicator = (mode_d == bhmc_pkg::MODE_HIGH);
    res_o.mid_indicator  = (mode_d == bhmc_pkg::MODE_MID);
    res_o.low_indicator  = (mode_d == bhmc_pkg::MODE_LOW);
    res_o.heater_drive   = heat_d;
    res_o.sleep_request  = sleep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= bhmc_pkg::MODE_OFF;
      tick_q  <= '0;
      press_q <= '0;
      seen_q  <= 1'b0;
      heat_q  <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      tick_q  <= tick_d;
      press_q <= press_d;
      seen_q  <= seen_d;
      heat_q  <= heat_d;
    end
  end

endmodule

>>> hw/rtl/button_heater_mode_controller_top.sv
// Top level of the button heater mode controller: input stage, core and result register.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_stall_o    | key_pressed_i
//   out     | output    | out_valid_o / out_stall_i  | power_mode_o, *_indicator_o,
//           |           |                            | heater_drive_o, sleep_request_o
//   cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One word per clock sustained while the output is not stalled. A word is held in the
// input register, and its result is then registered in the output register, where
// out_valid_o marks it. The core's state loop (press counter, mode, tick counter, heater
// level) advances once per word, which sets that rate.
// Reset (rst_ni low, asynchronous) empties both stages, puts the core in off mode
// with cleared counters and loads the register defaults.
// A stall on the output holds the result register; the input register then holds
// too, and in_stall_o rises once it is full.
module button_heater_mode_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          key_pressed_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    power_mode_o,
  output logic                          high_indicator_o,
  output logic                          mid_indicator_o,
  output logic                          low_indicator_o,
  output logic                          heater_drive_o,
  output logic                          sleep_request_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bhmc_pkg::AddrW-1:0]    paddr,
  input  logic [bhmc_pkg::DataW-1:0]    pwdata,
  output logic [bhmc_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  bhmc_pkg::cfg_t    cfg;
  bhmc_pkg::result_t res_next;
  bhmc_pkg::result_t res_q;

  logic s1_valid_q, s1_valid_d;
  logic s1_key_q;
  logic out_valid_q, out_valid_d;
  logic out_free;   // result register can take a word this cycle
  logic step;       // input word moves through the core
  logic in_take;

  bhmc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bhmc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .key_pressed_i (s1_key_q),
    .cfg_i         (cfg),
    .res_o         (res_next)
  );

  // Handshake: the input register refills in the same cycle it drains.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign step        = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_take || (s1_valid_q && !out_free);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_key_q <= key_pressed_i;
    end
    if (step) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign power_mode_o     = res_q.power_mode;
  assign high_indicator_o = res_q.high_indicator;
  assign mid_indicator_o  = res_q.mid_indicator;
  assign low_indicator_o  = res_q.low_indicator;
  assign heater_drive_o   = res_q.heater_drive;
  assign sleep_request_o  = res_q.sleep_request;

  // A sleep request always comes with off mode and the heater dropped.
  a_sleep_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sleep_request_o |-> power_mode_o == bhmc_pkg::MODE_OFF && !heater_drive_o)
    else $error("sleep request outside off mode or with heater on");

  // Preheat runs the heater flat out.
  a_preheat_heat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && power_mode_o == bhmc_pkg::MODE_PREHEAT |-> heater_drive_o)
    else $error("heater off during preheat");

  // At most one level indicator lit.
  a_ind_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({high_indicator_o, mid_indicator_o, low_indicator_o}))
    else $error("more than one power indicator lit");

  // A held input word is not lost while the output is blocked.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_key_q))
    else $error("input register lost a word under stall");

endmodule

>>> sim/bhmc_result_checker.sv
// Result checker for the button heater mode controller: predicts every result word and compares.
`timescale 1ns / 1ps
module bhmc_result_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       key_pressed_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [2:0]                 power_mode_i,
  input  logic                       high_indicator_i,
  input  logic                       mid_indicator_i,
  input  logic                       low_indicator_i,
  input  logic                       heater_drive_i,
  input  logic                       sleep_request_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [bhmc_pkg::AddrW-1:0] paddr_i,
  input  logic [bhmc_pkg::DataW-1:0] pwdata_i,
  output int unsigned                mismatches_o,
  output int unsigned                outstanding_o,
  output int unsigned                words_checked_o,
  output int unsigned                sleeps_seen_o
);
  import bhmc_pkg::*;

  cfg_t              regs;
  mode_e             mode_q;
  logic [CntW-1:0]   tick_q;
  logic [PressW-1:0] press_q;
  logic              long_seen_q;
  logic              heat_q;
  logic              sleep_q;
  result_t           pin_states_q[$];
  int unsigned       mismatches;
  int unsigned       words_checked;
  int unsigned       sleeps_seen;

  function automatic void restore_defaults();
    regs.long_press_ticks  = 12'd300;
    regs.stuck_key_ticks   = 12'd3000;
    regs.idle_sleep_ticks  = 16'd200;
    regs.duty_period_ticks = 16'd400;
    regs.preheat_ticks     = 16'd18000;
    regs.high_on_ticks     = 16'd300;
    regs.mid_on_ticks      = 16'd200;
    regs.low_on_ticks      = 16'd100;
    mode_q      = MODE_OFF;
    tick_q      = '0;
    press_q     = '0;
    long_seen_q = 1'b0;
    heat_q      = 1'b0;
    sleep_q     = 1'b0;
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [DataW-1:0] d);
    case (idx)
      REG_LONG_PRESS: regs.long_press_ticks  = d[11:0];
      REG_STUCK_KEY:  regs.stuck_key_ticks   = d[11:0];
      REG_IDLE_SLEEP: regs.idle_sleep_ticks  = d[15:0];
      REG_DUTY_PER:   regs.duty_period_ticks = d[15:0];
      REG_PREHEAT:    regs.preheat_ticks     = d[15:0];
      REG_HIGH_ON:    regs.high_on_ticks     = d[15:0];
      REG_MID_ON:     regs.mid_on_ticks      = d[15:0];
      REG_LOW_ON:     regs.low_on_ticks      = d[15:0];
      default: ;
    endcase
  endfunction

  // counter against a 16-bit register, zero-extended so an unreachable value never hits
  function automatic logic tick_at(input logic [15:0] mark);
    return CmpW'(tick_q) == CmpW'(mark);
  endfunction

  function automatic void shut_down();
    heat_q  = 1'b0;
    press_q = '0;
    tick_q  = '0;
    sleep_q = 1'b1;
  endfunction

  function automatic event_e classify_press(input logic key);
    event_e ev;
    ev = EV_NONE;
    if (key) begin
      if (press_q < PressMax) press_q = press_q + 1'b1;
      if (press_q >= regs.long_press_ticks) begin
        // timeout is only looked at once the long threshold is reached
        if (press_q >= regs.stuck_key_ticks) begin
          ev = EV_STUCK;
        end else if (!long_seen_q) begin
          long_seen_q = 1'b1;
          ev          = EV_LONG;
        end
      end
    end else begin
      if (press_q >= regs.long_press_ticks) long_seen_q = 1'b0;
      else if (press_q >= ShortMin) ev = EV_CLICK;
      press_q = '0;
    end
    return ev;
  endfunction

  function automatic result_t next_pin_state(input logic key);
    event_e      ev;
    logic [15:0] on_mark;
    result_t     r;
    ev      = classify_press(key);
    sleep_q = 1'b0;
    on_mark = '0;
    if (mode_q == MODE_PREHEAT) begin
      tick_q = tick_q - 1'b1;
      if (tick_q == '0) mode_q = MODE_MID;
    end
    if (ev == EV_CLICK && mode_q != MODE_OFF) begin
      tick_q = '0;
      case (mode_q)
        MODE_HIGH: mode_q = MODE_MID;
        MODE_MID:  mode_q = MODE_LOW;
        default:   mode_q = MODE_HIGH;
      endcase
    end else if (ev == EV_LONG && mode_q == MODE_OFF) begin
      mode_q = MODE_PREHEAT;
      tick_q = CntW'(regs.preheat_ticks);
    end else if (ev == EV_LONG || ev == EV_STUCK) begin
      mode_q = MODE_OFF;
      shut_down();
    end
    case (mode_q)
      MODE_OFF: begin
        if (press_q == '0) begin
          tick_q = tick_q + 1'b1;
          if (tick_at(regs.idle_sleep_ticks)) shut_down();
        end
      end
      MODE_HIGH: on_mark = regs.high_on_ticks;
      MODE_MID:  on_mark = regs.mid_on_ticks;
      MODE_LOW:  on_mark = regs.low_on_ticks;
      default:   heat_q = 1'b1;
    endcase
    if (mode_q == MODE_HIGH || mode_q == MODE_MID || mode_q == MODE_LOW) begin
      if (tick_at(on_mark)) heat_q = 1'b0;
      tick_q = tick_q + 1'b1;
      if (tick_at(regs.duty_period_ticks)) begin
        tick_q = '0;
        heat_q = 1'b1;
      end
    end
    r.power_mode     = mode_q;
    r.high_indicator = (mode_q == MODE_HIGH);
    r.mid_indicator  = (mode_q == MODE_MID);
    r.low_indicator  = (mode_q == MODE_LOW);
    r.heater_drive   = heat_q;
    r.sleep_request  = sleep_q;
    return r;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      restore_defaults();
      pin_states_q.delete();
      mismatches    = 0;
      words_checked = 0;
      sleeps_seen   = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) store_reg(paddr_i[4:2], pwdata_i);
      if (out_valid_i && !out_stall_i) begin
        if (pin_states_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: result word with none expected, expected nothing, got mode %0d",
                     $time, power_mode_i);
        end else begin
          want = pin_states_q.pop_front();
          words_checked++;
          if (want.sleep_request) sleeps_seen++;
          check_field("power_mode", want.power_mode, power_mode_i);
          check_field("high_indicator", want.high_indicator, high_indicator_i);
          check_field("mid_indicator", want.mid_indicator, mid_indicator_i);
          check_field("low_indicator", want.low_indicator, low_indicator_i);
          check_field("heater_drive", want.heater_drive, heater_drive_i);
          check_field("sleep_request", want.sleep_request, sleep_request_i);
        end
      end
      if (in_valid_i && !in_stall_i) pin_states_q.push_back(next_pin_state(key_pressed_i));
    end
    mismatches_o    <= mismatches;
    outstanding_o   <= pin_states_q.size();
    words_checked_o <= words_checked;
    sleeps_seen_o   <= sleeps_seen;
  end

endmodule

>>> sim/button_heater_mode_controller_top_test.sv
// Stimulus and verdict for the button heater mode controller, result checker alongside.
`timescale 1ns / 1ps
module button_heater_mode_controller_top_test;
  import bhmc_pkg::*;

  // Hang guard, well above the slowest legal run (every word waiting out the
  // longest gap and the longest stall).
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned RandomWords = 1850;
  localparam int unsigned RandPhases  = 9;
  // Caps the random click holds and gates long and stuck holds, so that thresholds near 4095 stay cheap.
  localparam int unsigned HoldCap     = 60;

  typedef enum int unsigned {
    SET_TYPICAL,
    SET_FLOOR,
    SET_CEILING
  } setting_kind_e;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic              key_pressed_i    = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [2:0]        power_mode_o;
  logic              high_indicator_o;
  logic              mid_indicator_o;
  logic              low_indicator_o;
  logic              heater_drive_o;
  logic              sleep_request_o;
  logic              psel             = 1'b0;
  logic              penable          = 1'b0;
  logic              pwrite           = 1'b0;
  logic [AddrW-1:0]  paddr            = '0;
  logic [DataW-1:0]  pwdata           = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // Calm phases run with no gaps and start no new output stalls.
  bit                calm             = 1'b0;
  int unsigned       words_sent       = 0;
  int unsigned       settings_used    = 0;
  int unsigned       stall_run        = 0;
  int unsigned       cycle_cnt        = 0;

  int unsigned       mismatches;
  int unsigned       outstanding;
  int unsigned       words_checked;
  int unsigned       sleeps_seen;

  button_heater_mode_controller_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .key_pressed_i    (key_pressed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .power_mode_o     (power_mode_o),
    .high_indicator_o (high_indicator_o),
    .mid_indicator_o  (mid_indicator_o),
    .low_indicator_o  (low_indicator_o),
    .heater_drive_o   (heater_drive_o),
    .sleep_request_o  (sleep_request_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // The checker sees both channels and the register port; it owns all prediction.
  bhmc_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .key_pressed_i    (key_pressed_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .power_mode_i     (power_mode_o),
    .high_indicator_i (high_indicator_o),
    .mid_indicator_i  (mid_indicator_o),
    .low_indicator_i  (low_indicator_o),
    .heater_drive_i   (heater_drive_o),
    .sleep_request_i  (sleep_request_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding),
    .words_checked_o  (words_checked),
    .sleeps_seen_o    (sleeps_seen)
  );

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short bursts, now and then a long one.
  function automatic int unsigned burst_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver side: random stall bursts, none started in calm phases.
  always @(posedge clk_i) begin
    if (stall_run != 0) stall_run--;
    else if (!calm && $urandom_range(0, 99) < 20) stall_run = burst_len();
    out_stall_i <= (stall_run != 0);
  end

  // One key word. Valid is only dropped when a gap follows, so a
  // back-to-back word never sees valid lowered and raised in one step.
  task automatic push_key(input logic key);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 99) < 60) ? 0 : burst_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    key_pressed_i <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic hold_key(input int unsigned n);
    repeat (n) push_key(1'b1);
  endtask

  task automatic free_key(input int unsigned n);
    repeat (n) push_key(1'b0);
  endtask

  // Setup then access; consecutive writes run back to back, the bus
  // is only parked once the whole set is in.
  task automatic reg_write(input logic [2:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  // Bits above each register's width carry junk; the block must drop them.
  task automatic apply_settings(input cfg_t s);
    reg_write(REG_LONG_PRESS, {4'($urandom()), s.long_press_ticks});
    reg_write(REG_STUCK_KEY,  {4'($urandom()), s.stuck_key_ticks});
    reg_write(REG_IDLE_SLEEP, s.idle_sleep_ticks);
    reg_write(REG_DUTY_PER,   s.duty_period_ticks);
    reg_write(REG_PREHEAT,    s.preheat_ticks);
    reg_write(REG_HIGH_ON,    s.high_on_ticks);
    reg_write(REG_MID_ON,     s.mid_on_ticks);
    reg_write(REG_LOW_ON,     s.low_on_ticks);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  // Drain: wait until every word is answered, then let the two-stage pipe go idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic cfg_t rand_settings(input setting_kind_e kind);
    cfg_t s;
    case (kind)
      SET_FLOOR: begin
        // long at one tick, stuck at two: every press is long and turns stuck if held on
        s.long_press_ticks  = 12'd1;
        s.stuck_key_ticks   = 12'd2;
        s.idle_sleep_ticks  = 16'd1;
        s.duty_period_ticks = 16'd1;
        s.preheat_ticks     = 16'd1;
        s.high_on_ticks     = 16'd0;
        s.mid_on_ticks      = 16'd0;
        s.low_on_ticks      = 16'd0;
      end
      SET_CEILING: begin
        s.long_press_ticks  = 12'hFFF;
        s.stuck_key_ticks   = 12'hFFF;
        s.idle_sleep_ticks  = 16'hFFFF;
        s.duty_period_ticks = 16'hFFFF;
        s.preheat_ticks     = 16'hFFFF;
        s.high_on_ticks     = 16'hFFFF;
        s.mid_on_ticks      = 16'hFFFF;
        s.low_on_ticks      = 16'hFFFF;
      end
      default: begin
        s.long_press_ticks = 12'($urandom_range(9, 40));
        // a quarter of the time the timeout sits at or under the long threshold
        if ($urandom_range(0, 3) == 0)
          s.stuck_key_ticks = 12'($urandom_range(2, s.long_press_ticks));
        else
          s.stuck_key_ticks = s.long_press_ticks + 12'($urandom_range(1, 40));
        s.idle_sleep_ticks  = 16'($urandom_range(1, 60));
        s.duty_period_ticks = 16'($urandom_range(1, 40));
        s.preheat_ticks     = 16'($urandom_range(1, 60));
        // on marks past the period are never hit: heater stays on
        s.high_on_ticks     = 16'($urandom_range(0, s.duty_period_ticks + 3));
        s.mid_on_ticks      = 16'($urandom_range(0, s.duty_period_ticks + 3));
        s.low_on_ticks      = 16'($urandom_range(0, s.duty_period_ticks + 3));
      end
    endcase
    return s;
  endfunction

  // Mostly whole press gestures with random lengths, plus glitches and noise.
  task automatic run_phase(input int unsigned n, input cfg_t s);
    int unsigned start;
    int unsigned len;
    int unsigned r;
    start = words_sent;
    while (words_sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        // short click; at tiny thresholds this turns into a long or stuck press
        if (s.long_press_ticks > 8) begin
          len = s.long_press_ticks - 1;
          if (len > HoldCap) len = HoldCap;
          len = $urandom_range(8, len);
        end else begin
          len = $urandom_range(1, 10);
        end
        hold_key(len);
        free_key($urandom_range(1, 3));
      end else if (r < 55 && s.long_press_ticks <= HoldCap) begin
        hold_key($urandom_range(s.long_press_ticks, s.long_press_ticks + 3));
        free_key($urandom_range(1, 2));
      end else if (r < 65 && s.stuck_key_ticks <= HoldCap + 40) begin
        hold_key($urandom_range(s.stuck_key_ticks, s.stuck_key_ticks + 4));
        free_key($urandom_range(1, 2));
      end else if (r < 75) begin
        hold_key($urandom_range(1, 7));
        free_key($urandom_range(1, 2));
      end else if (r < 87) begin
        // idle stretch, long enough to reach the sleep point when it is near
        len = s.idle_sleep_ticks + 2;
        if (len > 80) len = 80;
        free_key($urandom_range(1, len));
      end else begin
        repeat ($urandom_range(1, 8)) push_key(1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Run stopped at the cycle limit with %0d words outstanding.", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    cfg_t plan;
    cfg_t phase_set;
    setting_kind_e kind;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A few words on the reset values: idle ticks, a glitch, a click in off mode.
    free_key(2);
    hold_key(1);
    free_key(1);
    hold_key(9);
    free_key(1);
    settle();

    // Directed: small thresholds so each gesture is short.
    plan.long_press_ticks  = 12'd9;
    plan.stuck_key_ticks   = 12'd11;
    plan.idle_sleep_ticks  = 16'd2;
    plan.duty_period_ticks = 16'd3;
    plan.preheat_ticks     = 16'd20;
    plan.high_on_ticks     = 16'd1;
    plan.mid_on_ticks      = 16'd2;
    plan.low_on_ticks      = 16'd5;
    apply_settings(plan);
    free_key(3);               // idle in off mode; the counter is already past the sleep point
    hold_key(9);               // long press from off: preheat
    free_key(1);               // release past long threshold clears the flag
    hold_key(8);               // click while preheating: straight to high
    free_key(1);
    hold_key(11);              // long press while on: sleep, counter restarts
    free_key(1);
    hold_key(3);               // too short to count
    free_key(1);

    // Random phases, each with its own register set; floor and ceiling included.
    for (int unsigned p = 0; p < RandPhases; p++) begin
      settle();
      if (p == 1) kind = SET_FLOOR;
      else if (p == 3) kind = SET_CEILING;
      else kind = SET_TYPICAL;
      calm      = (p % 4 == 2);
      phase_set = rand_settings(kind);
      apply_settings(phase_set);
      run_phase(RandomWords / RandPhases, phase_set);
    end
    calm = 1'b0;
    settle();
    repeat (8) @(posedge clk_i);

    $display("Drove %0d key words under %0d register settings, floor and ceiling included.",
             words_sent, settings_used);
    $display("Compared %0d result words, %0d of them sleep requests.",
             words_checked, sleeps_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bhmc_pkg.sv
hw/rtl/bhmc_cfg.sv
hw/rtl/bhmc_core.sv
hw/rtl/button_heater_mode_controller_top.sv
sim/bhmc_result_checker.sv
sim/button_heater_mode_controller_top_test.sv
